[rtl/quad_pixel_coverage_texture_sampler_top_defines.svh]
// Assertion helpers for the checker file.
`ifndef QUAD_PIXEL_COVERAGE_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define QUAD_PIXEL_COVERAGE_TEXTURE_SAMPLER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QPCTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QPCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qpcts_pkg.sv]
`timescale 1ns / 1ps

package qpcts_pkg;

    // Coordinate slot width, weight fraction bits and divider geometry.
    localparam int CW     = 16;
    localparam int WFB    = 16;
    localparam int DW     = 34;
    localparam int NW     = 36;
    localparam int QB     = 21;
    localparam int LANES  = 4;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [16:0]   diff_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_VERTEX_0    = 3'd0,
        REG_VERTEX_1    = 3'd1,
        REG_VERTEX_2    = 3'd2,
        REG_VERTEX_3    = 3'd3,
        REG_SOURCE_RECT = 3'd4,
        REG_COLOR_ONLY  = 3'd5
    } reg_idx_t;

    // Per-triangle constants derived from the corners.
    typedef struct packed {
        diff_t             k1;
        diff_t             k2;
        diff_t             k3;
        diff_t             k4;
        coord_t            xc;
        coord_t            yc;
        logic [DW-1:0]     dabs;
        logic              dneg;
        logic              deg;
    } tset_t;

    // Setup values that depend on configuration only.
    typedef struct packed {
        coord_t              l;
        coord_t              r;
        coord_t              t;
        coord_t              b;
        logic signed [12:0]  bx_lo;
        logic signed [12:0]  bx_hi;
        logic signed [12:0]  by_lo;
        logic signed [12:0]  by_hi;
        logic                flat;
        logic                rect;
        logic                empty;
        tset_t [1:0]         tset;
    } setup_t;

    // Coverage flags that travel beside the divider lanes.
    typedef struct packed {
        logic fail;
        logic rect;
        logic pass0;
        logic pass1;
    } side_t;

    typedef struct packed {
        logic                       valid;
        logic [LANES-1:0][NW-1:0]   num;
        logic [LANES-1:0][DW-1:0]   dvs;
        side_t                      side;
    } div_in_t;

    typedef struct packed {
        logic                       valid;
        logic [LANES-1:0][QB-1:0]   q;
        side_t                      side;
    } div_out_t;

    typedef struct packed {
        logic        valid;
        logic        covered;
        logic [10:0] texel_x;
        logic [10:0] texel_y;
    } res_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QB-1:0] rq;
    } dstep_t;

    // Signed field of a packed corner: 0 = x, 1 = y, 2 = u, 3 = v.
    function automatic coord_t fld(input logic [63:0] v, input int comp);
        return coord_t'(v[comp*CW +: CW]);
    endfunction

    // One restoring division step: next numerator bit from the top of rq,
    // quotient bit shifted in at the bottom.
    function automatic dstep_t div_step(input logic [DW-1:0] rem,
                                        input logic [QB-1:0] rq,
                                        input logic [DW-1:0] dvs);
        logic [DW:0] t;
        dstep_t      o;
        t = {rem, rq[QB-1]};
        if (t >= {1'b0, dvs})
        begin
            o.rem = DW'(t - {1'b0, dvs});
            o.rq  = {rq[QB-2:0], 1'b1};
        end
        else
        begin
            o.rem = DW'(t);
            o.rq  = {rq[QB-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

[rtl/qpcts_cfg.sv]
`timescale 1ns / 1ps

module qpcts_cfg import qpcts_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic [3:0][63:0]  vtx,
    output logic [47:0]       src_rect,
    output logic              color_only,
    output setup_t            setup
);

    logic [3:0][63:0] vtx_reg;
    logic [47:0]      rect_reg;
    logic             color_reg;
    setup_t           setup_reg;
    setup_t           setup_next;
    reg_idx_t         idx;
    logic             wr;

    assign idx = reg_idx_t'(paddr[5:3]);
    assign wr  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_reg   <= '0;
            rect_reg  <= '0;
            color_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_VERTEX_0:    vtx_reg[0] <= pwdata;
                REG_VERTEX_1:    vtx_reg[1] <= pwdata;
                REG_VERTEX_2:    vtx_reg[2] <= pwdata;
                REG_VERTEX_3:    vtx_reg[3] <= pwdata;
                REG_SOURCE_RECT: rect_reg   <= pwdata[47:0];
                REG_COLOR_ONLY:  color_reg  <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (idx)
            REG_VERTEX_0:    prdata = vtx_reg[0];
            REG_VERTEX_1:    prdata = vtx_reg[1];
            REG_VERTEX_2:    prdata = vtx_reg[2];
            REG_VERTEX_3:    prdata = vtx_reg[3];
            REG_SOURCE_RECT: prdata = {16'b0, rect_reg};
            REG_COLOR_ONLY:  prdata = {63'b0, color_reg};
            default:         prdata = '0;
        endcase
    end

    // Derived setup: bounding box, rectangle detection, triangle areas.
    always_comb
    begin
        coord_t             xs [4];
        coord_t             ys [4];
        coord_t             us [4];
        coord_t             vs [4];
        logic signed [16:0] rp;
        logic signed [16:0] bp;
        logic               aligned;
        logic               para;
        logic signed [34:0] den;
        int                 ib;
        int                 ic;
        for (int k = 0; k < 4; k++)
        begin
            xs[k] = fld(vtx_reg[k], 0);
            ys[k] = fld(vtx_reg[k], 1);
            us[k] = fld(vtx_reg[k], 2);
            vs[k] = fld(vtx_reg[k], 3);
        end
        setup_next.l = xs[0];
        setup_next.r = xs[0];
        setup_next.t = ys[0];
        setup_next.b = ys[0];
        for (int k = 1; k < 4; k++)
        begin
            if (xs[k] < setup_next.l) setup_next.l = xs[k];
            if (xs[k] > setup_next.r) setup_next.r = xs[k];
            if (ys[k] < setup_next.t) setup_next.t = ys[k];
            if (ys[k] > setup_next.b) setup_next.b = ys[k];
        end
        rp = 17'(setup_next.r) + 17'sd15;
        bp = 17'(setup_next.b) + 17'sd15;
        setup_next.bx_lo = 13'(setup_next.l >>> 4);
        setup_next.by_lo = 13'(setup_next.t >>> 4);
        setup_next.bx_hi = 13'(rp >>> 4);
        setup_next.by_hi = 13'(bp >>> 4);
        // With four fraction bits the 0.01 tolerance only admits exact equality.
        setup_next.flat = (setup_next.r == setup_next.l) || (setup_next.b == setup_next.t);
        aligned = (xs[0] == setup_next.l) && (ys[0] == setup_next.t) &&
                  (xs[1] == setup_next.r) && (ys[1] == setup_next.t) &&
                  (xs[2] == setup_next.r) && (ys[2] == setup_next.b) &&
                  (xs[3] == setup_next.l) && (ys[3] == setup_next.b);
        para = ((17'(us[0]) + 17'(us[2])) == (17'(us[1]) + 17'(us[3]))) &&
               ((17'(vs[0]) + 17'(vs[2])) == (17'(vs[1]) + 17'(vs[3])));
        setup_next.rect  = aligned && (color_reg || para);
        setup_next.empty = !color_reg && ((rect_reg[35:24] <= rect_reg[11:0]) ||
                                          (rect_reg[47:36] <= rect_reg[23:12]));
        for (int t = 0; t < 2; t++)
        begin
            ib = (t == 0) ? 1 : 2;
            ic = (t == 0) ? 2 : 3;
            setup_next.tset[t].k1 = 17'(ys[ib]) - 17'(ys[ic]);
            setup_next.tset[t].k2 = 17'(xs[ic]) - 17'(xs[ib]);
            setup_next.tset[t].k3 = 17'(ys[ic]) - 17'(ys[0]);
            setup_next.tset[t].k4 = 17'(xs[0]) - 17'(xs[ic]);
            setup_next.tset[t].xc = xs[ic];
            setup_next.tset[t].yc = ys[ic];
            den = 35'(setup_next.tset[t].k1 * setup_next.tset[t].k4) -
                  35'(setup_next.tset[t].k2 * setup_next.tset[t].k3);
            setup_next.tset[t].dneg = den[34];
            setup_next.tset[t].dabs = den[34] ? DW'(-den) : DW'(den);
            setup_next.tset[t].deg  = setup_next.tset[t].dabs <= DW'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        setup_reg <= setup_next;
    end

    assign vtx        = vtx_reg;
    assign src_rect   = rect_reg;
    assign color_only = color_reg;
    assign setup      = setup_reg;

endmodule

[rtl/qpcts_front.sv]
`timescale 1ns / 1ps

module qpcts_front import qpcts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [10:0] pixel_x,
    input  logic [10:0] pixel_y,
    input  setup_t      setup,
    output div_in_t     div_in
);

    // Tolerance test: 100 * n >= -den.
    function automatic logic not_below(input logic signed [36:0] n,
                                       input logic signed [36:0] den);
        logic signed [43:0] s;
        s = 44'(n) * 44'sd100 + 44'(den);
        return !s[43];
    endfunction

    // Stage 1: captured pixel.
    logic               v1_reg, v1_next;
    logic [10:0]        px_reg, px_next;
    logic [10:0]        py_reg, py_next;

    // Stage 2: barycentric numerators and rectangle numerators.
    logic               v2_reg, v2_next;
    logic signed [35:0] n1_reg [2];
    logic signed [35:0] n1_next [2];
    logic signed [35:0] n2_reg [2];
    logic signed [35:0] n2_next [2];
    logic signed [35:0] ah_reg, ah_next;
    logic signed [35:0] av_reg, av_next;
    logic               bf_reg, bf_next;

    // Stage 3: divider operands.
    logic               v3_reg;
    div_in_t            d3_reg, d3_next;

    assign v1_next = in_valid;
    assign px_next = pixel_x;
    assign py_next = pixel_y;

    // Numerators at the pixel center and bounding box test.
    always_comb
    begin
        logic signed [17:0] cx;
        logic signed [17:0] cy;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [13:0] pxs;
        logic signed [13:0] pys;
        logic signed [16:0] dw;
        logic signed [16:0] dh;
        cx  = $signed({3'b000, px_reg, 4'b1000});
        cy  = $signed({3'b000, py_reg, 4'b1000});
        pxs = $signed({3'b000, px_reg});
        pys = $signed({3'b000, py_reg});
        for (int t = 0; t < 2; t++)
        begin
            dx = cx - 18'(setup.tset[t].xc);
            dy = cy - 18'(setup.tset[t].yc);
            n1_next[t] = 36'(setup.tset[t].k1 * dx) + 36'(setup.tset[t].k2 * dy);
            n2_next[t] = 36'(setup.tset[t].k3 * dx) + 36'(setup.tset[t].k4 * dy);
        end
        dw = 17'(setup.r) - 17'(setup.l);
        dh = 17'(setup.b) - 17'(setup.t);
        // Offset by eight widths keeps the rectangle numerator non-negative.
        ah_next = 36'(cx) - 36'(setup.l) + (36'(dw) <<< 3);
        av_next = 36'(cy) - 36'(setup.t) + (36'(dh) <<< 3);
        bf_next = (pxs < 14'(setup.bx_lo)) || (pxs >= 14'(setup.bx_hi)) ||
                  (pys < 14'(setup.by_lo)) || (pys >= 14'(setup.by_hi));
        v2_next = v1_reg;
    end

    // Sign fix, inside tests and lane selection.
    always_comb
    begin
        logic signed [36:0] den;
        logic signed [36:0] a1;
        logic signed [36:0] a2;
        logic signed [36:0] a3;
        logic [NW-1:0]      an1 [2];
        logic [NW-1:0]      an2 [2];
        logic               pass [2];
        logic signed [16:0] dw;
        logic signed [16:0] dh;
        for (int t = 0; t < 2; t++)
        begin
            den = $signed({3'b000, setup.tset[t].dabs});
            a1  = setup.tset[t].dneg ? -37'(n1_reg[t]) : 37'(n1_reg[t]);
            a2  = setup.tset[t].dneg ? -37'(n2_reg[t]) : 37'(n2_reg[t]);
            a3  = den - a1 - a2;
            pass[t] = !setup.tset[t].deg && not_below(a1, den) &&
                      not_below(a2, den) && not_below(a3, den);
            // Adding the area once keeps the weight numerator non-negative.
            an1[t] = NW'(a1 + den);
            an2[t] = NW'(a2 + den);
        end
        dw = 17'(setup.r) - 17'(setup.l);
        dh = 17'(setup.b) - 17'(setup.t);
        d3_next.valid = v2_reg;
        if (setup.rect)
        begin
            d3_next.num[0] = NW'($unsigned(ah_reg));
            d3_next.dvs[0] = DW'($unsigned(dw));
            d3_next.num[1] = NW'($unsigned(av_reg));
            d3_next.dvs[1] = DW'($unsigned(dh));
        end
        else
        begin
            d3_next.num[0] = an1[0];
            d3_next.dvs[0] = setup.tset[0].dabs;
            d3_next.num[1] = an2[0];
            d3_next.dvs[1] = setup.tset[0].dabs;
        end
        d3_next.num[2]     = an1[1];
        d3_next.dvs[2]     = setup.tset[1].dabs;
        d3_next.num[3]     = an2[1];
        d3_next.dvs[3]     = setup.tset[1].dabs;
        d3_next.side.fail  = bf_reg || setup.flat || setup.empty;
        d3_next.side.rect  = setup.rect;
        d3_next.side.pass0 = pass[0];
        d3_next.side.pass1 = pass[1];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= d3_next.valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            n1_reg <= n1_next;
            n2_reg <= n2_next;
            ah_reg <= ah_next;
            av_reg <= av_next;
            bf_reg <= bf_next;
            d3_reg <= d3_next;
        end
    end

    // The reset valid bit travels beside the stage 3 payload.
    always_comb
    begin
        div_in       = d3_reg;
        div_in.valid = v3_reg;
    end

endmodule

[rtl/qpcts_div.sv]
`timescale 1ns / 1ps

module qpcts_div import qpcts_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_in_t  din,
    output div_out_t dout
);

    // One quotient bit per stage and lane.
    logic          vld_reg  [QB];
    logic          vld_next [QB];
    side_t         side_reg  [QB];
    side_t         side_next [QB];
    logic [DW-1:0] rem_reg  [QB][LANES];
    logic [DW-1:0] rem_next [QB][LANES];
    logic [QB-1:0] rq_reg   [QB][LANES];
    logic [QB-1:0] rq_next  [QB][LANES];
    logic [DW-1:0] dvs_reg  [QB][LANES];
    logic [DW-1:0] dvs_next [QB][LANES];

    always_comb
    begin
        logic [DW-1:0] rem_in;
        logic [QB-1:0] rq_in;
        logic [DW-1:0] dvs_in;
        dstep_t        st;
        for (int s = 0; s < QB; s++)
        begin
            vld_next[s]  = (s == 0) ? din.valid : vld_reg[(s == 0) ? 0 : s-1];
            side_next[s] = (s == 0) ? din.side : side_reg[(s == 0) ? 0 : s-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                begin
                    // Numerator is num * 2^WFB; its top part is below the divisor.
                    rem_in = DW'(din.num[l][NW-1:QB-WFB]);
                    rq_in  = {din.num[l][QB-WFB-1:0], WFB'(0)};
                    dvs_in = din.dvs[l];
                end
                else
                begin
                    rem_in = rem_reg[(s == 0) ? 0 : s-1][l];
                    rq_in  = rq_reg[(s == 0) ? 0 : s-1][l];
                    dvs_in = dvs_reg[(s == 0) ? 0 : s-1][l];
                end
                st = div_step(rem_in, rq_in, dvs_in);
                rem_next[s][l] = st.rem;
                rq_next[s][l]  = st.rq;
                dvs_next[s][l] = dvs_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            rem_reg  <= rem_next;
            rq_reg   <= rq_next;
            dvs_reg  <= dvs_next;
        end
    end

    always_comb
    begin
        dout.valid = vld_reg[QB-1];
        dout.side  = side_reg[QB-1];
        for (int l = 0; l < LANES; l++)
        begin
            dout.q[l] = rq_reg[QB-1][l];
        end
    end

endmodule

[rtl/qpcts_back.sv]
`timescale 1ns / 1ps

module qpcts_back import qpcts_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  div_out_t          dout,
    input  logic [3:0][63:0]  vtx,
    input  logic [47:0]       src_rect,
    input  logic              color_only,
    output res_t              res
);

    localparam logic signed [23:0] W_ONE   = 24'sd65536;
    localparam logic signed [23:0] W_EIGHT = 24'sd524288;

    // Stage 1: weights and multiplier operands.
    logic               v1_reg, v1_next;
    logic               c1_reg, c1_next;
    logic signed [23:0] a_reg  [3];
    logic signed [23:0] a_next [3];
    logic signed [16:0] bu_reg  [3];
    logic signed [16:0] bu_next [3];
    logic signed [16:0] bv_reg  [3];
    logic signed [16:0] bv_next [3];

    // Stage 2: products.
    logic               v2_reg, v2_next;
    logic               c2_reg, c2_next;
    logic signed [40:0] pu_reg  [3];
    logic signed [40:0] pu_next [3];
    logic signed [40:0] pv_reg  [3];
    logic signed [40:0] pv_next [3];

    // Stage 3: floored texel coordinates.
    logic               v3_reg, v3_next;
    logic               c3_reg, c3_next;
    logic signed [22:0] tx_reg, tx_next;
    logic signed [22:0] ty_reg, ty_next;

    always_comb
    begin
        logic               t1;
        logic signed [23:0] w0;
        logic signed [23:0] w1;
        coord_t             us [4];
        coord_t             vs [4];
        t1 = 1'b0;
        w0 = '0;
        w1 = '0;
        for (int k = 0; k < 4; k++)
        begin
            us[k] = fld(vtx[k], 2);
            vs[k] = fld(vtx[k], 3);
        end
        v1_next = dout.valid;
        c1_next = !dout.side.fail &&
                  (dout.side.rect || dout.side.pass0 || dout.side.pass1);
        if (dout.side.rect)
        begin
            // Bilinear rectangle: u0 + v * (u3 - u0) + h * (u1 - u0).
            a_next[0]  = W_ONE;
            a_next[1]  = $signed({3'b000, dout.q[1]}) - W_EIGHT;
            a_next[2]  = $signed({3'b000, dout.q[0]}) - W_EIGHT;
            bu_next[0] = 17'(us[0]);
            bu_next[1] = 17'(us[3]) - 17'(us[0]);
            bu_next[2] = 17'(us[1]) - 17'(us[0]);
            bv_next[0] = 17'(vs[0]);
            bv_next[1] = 17'(vs[3]) - 17'(vs[0]);
            bv_next[2] = 17'(vs[1]) - 17'(vs[0]);
        end
        else
        begin
            // First triangle wins when both contain the center.
            t1 = !dout.side.pass0;
            w0 = $signed({3'b000, (t1 ? dout.q[2] : dout.q[0])}) - W_ONE;
            w1 = $signed({3'b000, (t1 ? dout.q[3] : dout.q[1])}) - W_ONE;
            a_next[0]  = w0;
            a_next[1]  = w1;
            a_next[2]  = W_ONE - w0 - w1;
            bu_next[0] = 17'(us[0]);
            bu_next[1] = t1 ? 17'(us[2]) : 17'(us[1]);
            bu_next[2] = t1 ? 17'(us[3]) : 17'(us[2]);
            bv_next[0] = 17'(vs[0]);
            bv_next[1] = t1 ? 17'(vs[2]) : 17'(vs[1]);
            bv_next[2] = t1 ? 17'(vs[3]) : 17'(vs[2]);
        end
    end

    always_comb
    begin
        v2_next = v1_reg;
        c2_next = c1_reg;
        for (int i = 0; i < 3; i++)
        begin
            pu_next[i] = a_reg[i] * bu_reg[i];
            pv_next[i] = a_reg[i] * bv_reg[i];
        end
    end

    // Sum and floor by the weight scale times the coordinate scale.
    always_comb
    begin
        logic signed [42:0] su;
        logic signed [42:0] sv;
        su = 43'(pu_reg[0]) + 43'(pu_reg[1]) + 43'(pu_reg[2]);
        sv = 43'(pv_reg[0]) + 43'(pv_reg[1]) + 43'(pv_reg[2]);
        tx_next = 23'(su >>> 20);
        ty_next = 23'(sv >>> 20);
        v3_next = v2_reg;
        c3_next = c2_reg;
    end

    // Clamp to the source rectangle; no texel for uncovered or solid fill.
    always_comb
    begin
        logic signed [22:0] xlo;
        logic signed [22:0] xhi;
        logic signed [22:0] ylo;
        logic signed [22:0] yhi;
        logic signed [22:0] xc;
        logic signed [22:0] yc;
        xlo = $signed({11'b0, src_rect[11:0]});
        ylo = $signed({11'b0, src_rect[23:12]});
        xhi = $signed({11'b0, src_rect[35:24]}) - 23'sd1;
        yhi = $signed({11'b0, src_rect[47:36]}) - 23'sd1;
        xc  = (tx_reg < xlo) ? xlo : ((tx_reg > xhi) ? xhi : tx_reg);
        yc  = (ty_reg < ylo) ? ylo : ((ty_reg > yhi) ? yhi : ty_reg);
        res.valid   = v3_reg;
        res.covered = c3_reg;
        res.texel_x = (c3_reg && !color_only) ? xc[10:0] : 11'd0;
        res.texel_y = (c3_reg && !color_only) ? yc[10:0] : 11'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
            a_reg  <= a_next;
            bu_reg <= bu_next;
            bv_reg <= bv_next;
            pu_reg <= pu_next;
            pv_reg <= pv_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

endmodule

[rtl/quad_pixel_coverage_texture_sampler_top.sv]
`timescale 1ns / 1ps
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+----------------------------------
// pixel in | in_valid / in_stall           | pixel_x, pixel_y
// result   | out_valid / out_stall         | covered, texel_x, texel_y
// config   | psel, penable, pwrite, pready | paddr, pwdata, prdata (64 bits)
//
// One transaction is accepted per cycle while in_stall is low; each result
// passes through the 21-stage restoring divider for the weights.
// Reset clears all configuration registers and every valid bit in the pipe.
// A stalled result parks in a one-entry skid buffer; while it is occupied the
// whole pipeline holds and in_stall is high, starting the cycle after.

module quad_pixel_coverage_texture_sampler_top import qpcts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [10:0] pixel_x,
    input  logic [10:0] pixel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        covered,
    output logic [10:0] texel_x,
    output logic [10:0] texel_y
);

    logic [3:0][63:0] vtx;
    logic [47:0]      src_rect;
    logic             color_only;
    setup_t           setup;
    div_in_t          div_in;
    div_out_t         div_out;
    res_t             res;
    logic             en;

    logic             out_vld_reg, out_vld_next;
    res_t             out_reg, out_next;
    logic             skid_vld_reg, skid_vld_next;
    res_t             skid_reg, skid_next;

    assign pready   = 1'b1;
    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    qpcts_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .vtx        (vtx),
        .src_rect   (src_rect),
        .color_only (color_only),
        .setup      (setup)
    );

    qpcts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .setup    (setup),
        .div_in   (div_in)
    );

    qpcts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (div_in),
        .dout  (div_out)
    );

    qpcts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .dout       (div_out),
        .vtx        (vtx),
        .src_rect   (src_rect),
        .color_only (color_only),
        .res        (res)
    );

    // Output register with a skid entry behind it.
    always_comb
    begin
        logic take;
        take          = out_vld_reg && !out_stall;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!out_vld_reg || take)
            begin
                out_next     = res;
                out_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = res;
                skid_vld_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_vld_reg;
    assign covered   = out_reg.covered;
    assign texel_x   = out_reg.texel_x;
    assign texel_y   = out_reg.texel_y;

endmodule

[rtl/qpcts_checker.sv]
`timescale 1ns / 1ps
`include "quad_pixel_coverage_texture_sampler_top_defines.svh"

module qpcts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        covered,
    input logic [10:0] texel_x,
    input logic [10:0] texel_y
);

    // A stalled result stays offered.
    `QPCTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // An uncovered pixel never carries a texel.
    `QPCTS_ASSERT_NOW(a_uncov_zero, out_valid && !covered, texel_x == 11'd0 && texel_y == 11'd0, "texel on uncovered pixel")

    // The input only stalls after the output was stalled.
    `QPCTS_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stall without output stall")

    // While the skid entry is full a result is being offered.
    `QPCTS_ASSERT_NOW(a_stall_out, in_stall, out_valid, "input stalled with no result pending")

endmodule

bind quad_pixel_coverage_texture_sampler_top qpcts_checker u_qpcts_checker (.*);
